// ----- hdl/lmscn_pkg.sv -----
// ============================================================================
// lmscn_pkg: shared types, constants and helpers of the LDPC check-node unit
// Holds the front-to-back command beat, the queue status, the back-end
// state encoding and the LLR saturation and magnitude helpers.
// ============================================================================
package lmscn_pkg;

    // LLR limits
    localparam logic signed [7:0] LLR_MAX   = 8'sd127;
    localparam logic signed [7:0] LLR_MIN   = -8'sd127;
    localparam logic signed [8:0] LLR_MAX_W = 9'sd127;
    localparam logic signed [8:0] LLR_MIN_W = -9'sd127;
    localparam logic [6:0]        MAG_INIT  = 7'd127;

    // command queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // one edge handed from front to back
    typedef struct packed {
        logic              close;    // last edge of the node
        logic signed [7:0] diff;     // saturated posterior minus old message
        logic [6:0]        min1;     // node minima, valid with close
        logic [6:0]        min2;
        logic              parity;   // sign parity of the node, valid with close
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_back_state;

    // clamp a 9-bit sum to [-127, 127]
    function automatic logic signed [7:0] sat127(input logic signed [8:0] v);
        logic signed [7:0] r;
        if (v > LLR_MAX_W) begin
            r = LLR_MAX;
        end else if (v < LLR_MIN_W) begin
            r = LLR_MIN;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    // magnitude of a value already in [-127, 127]
    function automatic logic [6:0] mag7(input logic signed [7:0] v);
        logic [7:0] neg;
        neg = 8'(-v);
        return v[7] ? neg[6:0] : v[6:0];
    endfunction

endpackage

// ----- hdl/lmscn_front.sv -----
// ============================================================================
// lmscn_front: edge intake and node statistics
// Accepts edges, forms the saturated difference, tracks the two smallest
// magnitudes and the sign parity, and pushes one command beat per edge.
// ============================================================================
module lmscn_front #(
    parameter int MAX_DEGREE = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [7:0]      i_posterior_in,
    input  logic signed [7:0]      i_old_message,
    input  logic                   i_last_edge,
    input  lmscn_pkg::t_q_status   i_q_status,
    output logic                   o_push,
    output lmscn_pkg::t_cmd        o_cmd
);
    import lmscn_pkg::*;

    localparam int IDXW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(MAX_DEGREE - 1);

    logic [6:0]      r_min1, n_min1;
    logic [6:0]      r_min2, n_min2;
    logic            r_parity, n_parity;
    logic [IDXW-1:0] r_cnt;

    logic signed [8:0] diff_w;
    logic signed [7:0] diff;
    logic [6:0]        mag;
    logic              close;

    assign busy   = i_q_status.full;
    assign o_push = start && !busy;

    // difference and its magnitude
    always_comb begin
        diff_w = 9'(i_posterior_in) - 9'(i_old_message);
        diff   = sat127(diff_w);
        mag    = mag7(diff);
        close  = i_last_edge || (r_cnt == LAST_SLOT);
    end

    // running minima and parity including this edge
    always_comb begin
        n_min1   = r_min1;
        n_min2   = r_min2;
        n_parity = r_parity ^ diff[7];
        if (mag < r_min1) begin
            n_min2 = r_min1;
            n_min1 = mag;
        end else if (mag < r_min2) begin
            n_min2 = mag;
        end
    end

    // command beat
    always_comb begin
        o_cmd.close  = close;
        o_cmd.diff   = diff;
        o_cmd.min1   = n_min1;
        o_cmd.min2   = n_min2;
        o_cmd.parity = n_parity;
    end

    // node statistics, cleared when a node closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min1   <= MAG_INIT;
            r_min2   <= MAG_INIT;
            r_parity <= 1'b0;
            r_cnt    <= '0;
        end else if (o_push) begin
            if (close) begin
                r_min1   <= MAG_INIT;
                r_min2   <= MAG_INIT;
                r_parity <= 1'b0;
                r_cnt    <= '0;
            end else begin
                r_min1   <= n_min1;
                r_min2   <= n_min2;
                r_parity <= n_parity;
                r_cnt    <= r_cnt + 1'b1;
            end
        end
    end

endmodule

// ----- hdl/lmscn_queue.sv -----
// ============================================================================
// lmscn_queue: short command queue between front and back
// Two-entry FIFO of command beats; reports full and empty as one status.
// ============================================================================
module lmscn_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  lmscn_pkg::t_cmd        i_cmd,
    input  logic                   i_pop,
    output lmscn_pkg::t_cmd        o_cmd,
    output lmscn_pkg::t_q_status   o_status
);
    import lmscn_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/lmscn_back.sv -----
// ============================================================================
// lmscn_back: edge buffer and message emission
// Stores each edge difference; on a closing beat it replays the node in
// arrival order and emits the new message and posterior for every edge.
// ============================================================================
module lmscn_back #(
    parameter int MAX_DEGREE = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lmscn_pkg::t_cmd        i_cmd,
    input  lmscn_pkg::t_q_status   i_q_status,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic signed [7:0]      o_new_message,
    output logic signed [7:0]      o_new_posterior,
    output logic                   o_last_out
);
    import lmscn_pkg::*;

    localparam int IDXW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    t_back_state r_state, n_state;

    logic signed [7:0] r_mem [MAX_DEGREE];
    logic [IDXW-1:0]   r_wr_cnt;
    logic [IDXW-1:0]   r_last_idx;
    logic [IDXW-1:0]   r_rd_idx;
    logic [6:0]        r_min1;
    logic [6:0]        r_min2;
    logic              r_parity;

    logic signed [7:0] r_rd_data;
    logic              r_rd_vld;
    logic              r_rd_last;

    logic              r_valid;
    logic signed [7:0] r_msg;
    logic signed [7:0] r_post;
    logic              r_last;

    logic              rd_en;
    logic              rd_end;
    logic              pop_close;

    logic [6:0]        rd_mag;
    logic [6:0]        mg;
    logic              neg;
    logic signed [7:0] msg;
    logic signed [8:0] sum;

    assign rd_end    = (r_rd_idx == r_last_idx);
    assign pop_close = o_pop && i_cmd.close;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: if (pop_close) n_state = ST_EMIT;
            ST_EMIT: if (rd_end)    n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop = 1'b0;
        rd_en = 1'b0;
        unique case (r_state)
            ST_LOAD: o_pop = !i_q_status.empty;
            ST_EMIT: rd_en = 1'b1;
            default: begin
                o_pop = 1'b0;
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // edge buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[r_wr_cnt] <= i_cmd.diff;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // write count, node summary and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_cnt <= '0;
            r_rd_idx <= '0;
        end else begin
            if (o_pop) begin
                r_wr_cnt <= i_cmd.close ? '0 : r_wr_cnt + 1'b1;
            end
            if (rd_en) begin
                r_rd_idx <= rd_end ? '0 : r_rd_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_close) begin
            r_last_idx <= r_wr_cnt;
            r_min1     <= i_cmd.min1;
            r_min2     <= i_cmd.min2;
            r_parity   <= i_cmd.parity;
        end
    end

    // read-data valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_rd_vld  <= rd_en;
            r_rd_last <= rd_en && rd_end;
            r_valid   <= r_rd_vld;
        end
    end

    // new message: other minimum, sign of the other edges
    always_comb begin
        rd_mag = mag7(r_rd_data);
        mg     = (rd_mag == r_min1) ? r_min2 : r_min1;
        neg    = r_parity ^ r_rd_data[7];
        msg    = neg ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
        sum    = 9'(r_rd_data) + 9'(msg);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_msg  <= msg;
            r_post <= sat127(sum);
            r_last <= r_rd_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_new_message   = r_msg;
    assign o_new_posterior = r_post;
    assign o_last_out      = r_last;

endmodule

// ----- hdl/ldpc_min_sum_check_node.sv -----
// ============================================================================
// ldpc_min_sum_check_node: layered int8 min-sum LDPC check-node unit
// Edges enter on start/busy; one result per edge leaves on o_valid once
// the node closes, in arrival order.
// ============================================================================
// Path: a node's last edge passes the queue entry, the back end's pop into
// the emit state, the edge-buffer read and the result register, when the
// back end is free; the node's n results then follow one a cycle.
// Throughput: one edge a cycle while the 2-beat queue has room; the back
// end buffers all edges of a node, then reads them back before it pops again.
// Reset: synchronous, active low; clears queue, counters and node minima,
// the edge buffer is not cleared. Results cannot be stalled by the receiver.
module ldpc_min_sum_check_node #(
    parameter int MAX_DEGREE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [7:0] i_posterior_in,
    input  logic signed [7:0] i_old_message,
    input  logic              i_last_edge,
    output logic              o_valid,
    output logic signed [7:0] o_new_message,
    output logic signed [7:0] o_new_posterior,
    output logic              o_last_out
);
    import lmscn_pkg::*;

    logic      push;
    logic      pop;
    t_cmd      front_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;

    // edge intake
    lmscn_front #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_posterior_in (i_posterior_in),
        .i_old_message  (i_old_message),
        .i_last_edge    (i_last_edge),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    // decoupling queue
    lmscn_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // buffer and emission
    lmscn_back #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_new_message   (o_new_message),
        .o_new_posterior (o_new_posterior),
        .o_last_out      (o_last_out)
    );

endmodule
